// File: sv/locd_pkg.sv
// Shared types and codes for the lock-order cycle detector.
package locd_pkg;

  localparam int IdWidth     = 5;
  localparam int CountWidth  = 5;
  localparam int StatusWidth = 3;

  localparam logic [StatusWidth-1:0] ST_OK       = 3'd0;
  localparam logic [StatusWidth-1:0] ST_EMPTY    = 3'd1;
  localparam logic [StatusWidth-1:0] ST_NOT_TOP  = 3'd2;
  localparam logic [StatusWidth-1:0] ST_DEADLOCK = 3'd3;
  localparam logic [StatusWidth-1:0] ST_FULL     = 3'd4;

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [IdWidth-1:0] lock_id;
  } in_item_t;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [CountWidth-1:0]  held_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                   load_item;
    logic                   stack_rd;
    logic                   edge_rd;
    logic                   edge_wr;
    logic                   walk_init;
    logic                   walk_pick;
    logic                   walk_step;
    logic                   push;
    logic                   pop;
    logic                   finish;
    logic [StatusWidth-1:0] code;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [StatusWidth-1:0] fault_code;
    logic                   out_of_range;
    logic                   is_release;
    logic                   stack_empty;
    logic                   stack_full;
    logic                   top_match;
    logic                   edge_known;
    logic                   pending_empty;
    logic                   found;
  } dp_stat_t;

endpackage

// File: sv/lock_order_cycle_detector_top.sv
// Lock-order cycle detector. Each input item acquires or releases a numbered
// lock; the block keeps a stack of held locks and a lock-order graph, and
// returns one result item per input item with a status and the number of
// locks now held. An item that needs no graph walk finishes in the CHECK,
// TOP_CHK or EDGE_CHK state, the last when an edge has to be looked up, once
// the output register is free. An acquire that records a new edge walks the
// graph from the new lock, expanding one reached lock at a time in the PICK
// and STEP states through the single read port of the edge memory. One item
// is in work at a time; the next item is taken while the previous result
// still waits in the output register. Faults are sticky until reset.
module lock_order_cycle_detector_top #(
  parameter int LOCK_COUNT  = 32,
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  locd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output locd_pkg::out_item_t out_item
);

  locd_pkg::dp_cmd_t  cmd;
  locd_pkg::dp_stat_t stat;

  locd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  locd_dp #(
    .LOCK_COUNT  (LOCK_COUNT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

// File: sv/locd_dp.sv
// Datapath: held-lock stack, lock-order edge memory and reachability walk sets.
module locd_dp #(
  parameter int LOCK_COUNT  = 32,
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  locd_pkg::in_item_t  in_item,
  input  locd_pkg::dp_cmd_t   cmd,
  output locd_pkg::dp_stat_t  stat,
  output locd_pkg::out_item_t out_item
);

  localparam int LW  = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW  = $clog2(STACK_DEPTH + 1);

  locd_pkg::in_item_t item;
  logic [DW-1:0]      depth;
  logic [DW-1:0]      depth_next;
  logic [locd_pkg::StatusWidth-1:0] fault;

  // held-lock stack
  logic [locd_pkg::IdWidth-1:0] stack_mem [STACK_DEPTH];
  logic [locd_pkg::IdWidth-1:0] stack_q;

  // lock-order edges, one row per lock
  logic [LOCK_COUNT-1:0] edge_mem [LOCK_COUNT];
  logic [LOCK_COUNT-1:0] row_valid;
  logic [LOCK_COUNT-1:0] row_q;
  logic                  row_q_valid;
  logic [LOCK_COUNT-1:0] row_eff;

  logic [LOCK_COUNT-1:0] pending;
  logic [LOCK_COUNT-1:0] visited;
  logic [LOCK_COUNT-1:0] lowest;
  logic [LOCK_COUNT-1:0] new_bits;
  logic [LOCK_COUNT-1:0] id_bit;

  logic [LW-1:0] id_idx;
  logic [LW-1:0] top_idx;
  logic [LW-1:0] pick_idx;
  logic [LW-1:0] row_addr;

  assign id_idx   = LW'(item.lock_id);
  assign top_idx  = LW'(stack_q);
  assign id_bit   = LOCK_COUNT'(1) << id_idx;
  assign row_eff  = row_q_valid ? row_q : '0;
  assign new_bits = row_eff & ~visited;
  assign lowest   = pending & (~pending + LOCK_COUNT'(1));
  assign row_addr = cmd.walk_pick ? pick_idx : top_idx;

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < LOCK_COUNT; i++) begin
      if (lowest[i]) begin
        pick_idx = pick_idx | LW'(i);
      end
    end
  end

  always_comb begin
    depth_next = depth;
    if (cmd.push) begin
      depth_next = depth + DW'(1);
    end else if (cmd.pop) begin
      depth_next = depth - DW'(1);
    end
  end

  always_comb begin
    stat.fault_code    = fault;
    stat.out_of_range  = int'(item.lock_id) >= LOCK_COUNT;
    stat.is_release    = item.kind == locd_pkg::KIND_RELEASE;
    stat.stack_empty   = depth == '0;
    stat.stack_full    = depth >= DW'(STACK_DEPTH);
    stat.top_match     = stack_q == item.lock_id;
    stat.edge_known    = row_eff[id_idx];
    stat.pending_empty = pending == '0;
    stat.found         = new_bits[top_idx];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      fault     <= locd_pkg::ST_OK;
      row_valid <= '0;
    end else begin
      depth <= depth_next;
      if (cmd.finish) begin
        fault <= cmd.code;
      end
      if (cmd.edge_wr) begin
        row_valid[top_idx] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_item;
    end
    if (cmd.finish) begin
      out_item.status     <= cmd.code;
      out_item.held_count <= locd_pkg::CountWidth'(depth_next);
    end
    if (cmd.walk_init) begin
      pending <= id_bit;
      visited <= id_bit;
    end else if (cmd.walk_pick) begin
      pending <= pending & ~lowest;
    end else if (cmd.walk_step) begin
      pending <= pending | new_bits;
      visited <= visited | new_bits;
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[SAW'(depth)] <= item.lock_id;
    end
    if (cmd.stack_rd) begin
      stack_q <= stack_mem[SAW'(depth - DW'(1))];
    end
  end

  // edge memory
  always_ff @(posedge clk) begin
    if (cmd.edge_wr) begin
      edge_mem[top_idx] <= row_eff | id_bit;
    end
    if (cmd.edge_rd || cmd.walk_pick) begin
      row_q       <= edge_mem[row_addr];
      row_q_valid <= row_valid[row_addr];
    end
  end

endmodule

// File: sv/locd_ctrl.sv
// Controller: sequences stack, edge and walk steps for one item at a time.
module locd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  locd_pkg::dp_stat_t stat,
  output locd_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    TOP_CHK,
    EDGE_CHK,
    PICK,
    STEP
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = CHECK;
        end
      end
      CHECK: begin
        if (stat.fault_code != locd_pkg::ST_OK) begin
          cmd.finish = out_free;
          cmd.code   = stat.fault_code;
        end else if (stat.out_of_range) begin
          cmd.finish = out_free;
          cmd.code   = locd_pkg::ST_OK;
        end else if (stat.is_release) begin
          if (stat.stack_empty) begin
            cmd.finish = out_free;
            cmd.code   = locd_pkg::ST_EMPTY;
          end else begin
            cmd.stack_rd = 1'b1;
            state_next   = TOP_CHK;
          end
        end else if (stat.stack_full) begin
          cmd.finish = out_free;
          cmd.code   = locd_pkg::ST_FULL;
        end else if (stat.stack_empty) begin
          cmd.finish = out_free;
          cmd.push   = out_free;
          cmd.code   = locd_pkg::ST_OK;
        end else begin
          cmd.stack_rd = 1'b1;
          state_next   = TOP_CHK;
        end
      end
      TOP_CHK: begin
        if (stat.is_release) begin
          cmd.finish = out_free;
          cmd.pop    = out_free && stat.top_match;
          cmd.code   = stat.top_match ? locd_pkg::ST_OK : locd_pkg::ST_NOT_TOP;
        end else if (stat.top_match) begin
          cmd.finish = out_free;
          cmd.push   = out_free;
          cmd.code   = locd_pkg::ST_OK;
        end else begin
          cmd.edge_rd = 1'b1;
          state_next  = EDGE_CHK;
        end
      end
      EDGE_CHK: begin
        if (stat.edge_known) begin
          cmd.finish = out_free;
          cmd.push   = out_free;
          cmd.code   = locd_pkg::ST_OK;
        end else begin
          // record the new edge and start the walk from the new lock
          cmd.edge_wr   = 1'b1;
          cmd.walk_init = 1'b1;
          state_next    = PICK;
        end
      end
      PICK: begin
        if (stat.pending_empty) begin
          cmd.finish = out_free;
          cmd.push   = out_free;
          cmd.code   = locd_pkg::ST_OK;
        end else begin
          cmd.walk_pick = 1'b1;
          state_next    = STEP;
        end
      end
      STEP: begin
        if (stat.found) begin
          cmd.finish = out_free;
          cmd.code   = locd_pkg::ST_DEADLOCK;
        end else begin
          cmd.walk_step = 1'b1;
          state_next    = PICK;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
    if (cmd.finish) begin
      state_next = IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.finish || (out_valid && out_stall);
    end
  end

endmodule

// File: sv/locd_checker.sv
// Port-level checks for the lock-order cycle detector, bound to the top level.
module locd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input locd_pkg::out_item_t out_item
);

  logic in_acc;
  logic out_acc;
  logic [1:0] outstanding;
  logic seen_fault;
  logic [locd_pkg::StatusWidth-1:0] seen_code;
  logic [locd_pkg::CountWidth-1:0]  last_count;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      seen_fault  <= 1'b0;
      seen_code   <= locd_pkg::ST_OK;
      last_count  <= '0;
    end else begin
      outstanding <= outstanding + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        last_count <= out_item.held_count;
        if (out_item.status != locd_pkg::ST_OK) begin
          seen_fault <= 1'b1;
          seen_code  <= out_item.status;
        end
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_fault |-> out_item.status == seen_code
                                && out_item.held_count == last_count)
    else $error("fault not sticky");

  a_fault_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != locd_pkg::ST_OK |->
      out_item.held_count == last_count)
    else $error("faulting item changed held count");

  a_step: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.held_count == last_count
               || out_item.held_count == last_count + 5'd1
               || out_item.held_count == last_count - 5'd1)
    else $error("held count moved by more than one");

  a_flight: assert property (@(posedge clk) disable iff (rst)
    (in_acc |-> outstanding <= 2'd1) and (out_valid |-> outstanding != 2'd0))
    else $error("result without item or too many items in flight");

endmodule

bind lock_order_cycle_detector_top locd_checker u_locd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
